// ----- rtl/hufp_pkg.sv -----
// Shared types, constants and a helper function for the Huffman table bit packer.
// No dependencies; the bit packer top level imports this package.
package hufp_pkg;

  localparam int MAX_CODE_BITS = 32;
  localparam int WORD_BITS     = 64;
  localparam int SYM_BITS      = 8;
  localparam int LEN_BITS      = 6;
  localparam int FILL_BITS     = 6;
  localparam int CNT_BITS      = 4;
  localparam int TABLE_DEPTH   = 1 << SYM_BITS;
  localparam int ENTRY_BITS    = MAX_CODE_BITS + LEN_BITS;

  localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_CODE_BITS);
  localparam logic [7:0]          BYTE_MASK = 8'hff;
  localparam logic [CNT_BITS-1:0] FULL_WORD_BYTES = CNT_BITS'(WORD_BITS / 8);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  // One table entry: the code in the low bits, its length above it.
  typedef struct packed {
    logic [LEN_BITS-1:0]      len;
    logic [MAX_CODE_BITS-1:0] code;
  } entry_t;

  // Mask with the low w bits set; w may reach the full word width.
  function automatic logic [WORD_BITS-1:0] low_mask(input logic [FILL_BITS:0] w);
    logic [WORD_BITS-1:0] m;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (FILL_BITS+1)'(i) < w;
    end
    return m;
  endfunction

endpackage

// ----- rtl/hufp_table_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// No dependencies; used by the bit packer top level for its code table.
module hufp_table_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/huffman_table_bit_packer_core.sv -----
// Top level of the Huffman table bit packer: table RAM, packing stage, output register.
// Depends on hufp_pkg and hufp_table_ram.
//
//   Channel | Direction | tdata (low bit up)                          | tuser / tlast
//   --------+-----------+---------------------------------------------+----------------------
//   in_     | slave     | symbol[7:0], code_bits[39:8], code_length    | tuser[1:0] operation
//           |           | [45:40], zero fill to 48 bits               |
//   out_    | master    | packed_word[63:0]                           | tuser[3:0] byte_count,
//           |           |                                             | tlast is_last
//
// One word is accepted every cycle while in_tready is high. A load writes the table at its
// accept edge; an encode or flush reads the table at its accept edge, is packed from the
// registered read data in the packing stage, and its result, if it makes one, is then
// written to the output register.
// Reset (rst_n low, synchronous) clears the accumulator, fill count, low-bit record and
// all valid flags; the table keeps its contents and is undefined until loaded.
// in_tready drops only when the packing stage holds a result-making word while the
// output register holds a result that out_tready has not yet taken.
module huffman_table_bit_packer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // symbol[7:0], code_bits[39:8], code_length[45:40]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // packed_word[63:0]
  output logic [3:0]  out_tuser,  // byte_count[3:0]
  output logic        out_tlast
);
  import hufp_pkg::*;

  // Input field decode.
  logic [SYM_BITS-1:0]      in_symbol;
  logic [MAX_CODE_BITS-1:0] in_code;
  logic [LEN_BITS-1:0]      in_len;
  logic [LEN_BITS-1:0]      in_len_sat;
  logic                     in_fire;
  entry_t                   wr_entry;
  entry_t                   rd_entry;

  assign in_symbol  = in_tdata[7:0];
  assign in_code    = in_tdata[39:8];
  assign in_len     = in_tdata[45:40];
  // Lengths beyond the widest code saturate when they are stored.
  assign in_len_sat = (in_len > MAX_LEN) ? MAX_LEN : in_len;
  assign in_fire    = in_tvalid && in_tready;

  assign wr_entry.code = in_code;
  assign wr_entry.len  = in_len_sat;

  // The table is read for every accepted word; only encodes use the data. A load
  // writes at its own edge, so an encode of that entry accepted after it sees it.
  hufp_table_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (in_fire && (in_tuser == OP_LOAD)),
    .re    (in_fire),
    .addr  (in_symbol),
    .wdata (wr_entry),
    .rdata (rd_entry)
  );

  // Packing stage registers.
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [1:0]             s1_op_r;
  logic [WORD_BITS-1:0]   acc_r,  acc_nxt;
  logic [FILL_BITS-1:0]   fill_r, fill_nxt;
  logic                   low_bit_r, low_bit_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0]   out_word_r,  out_word_nxt;
  logic [CNT_BITS-1:0]    out_cnt_r,   out_cnt_nxt;
  logic                   out_last_r,  out_last_nxt;

  // Packing datapath.
  logic [MAX_CODE_BITS-1:0]           code_masked;
  logic [FILL_BITS:0]                 total;
  logic [WORD_BITS+MAX_CODE_BITS-1:0] shifted;
  logic [WORD_BITS-1:0]               pad_mask;
  logic [WORD_BITS-1:0]               flush_word;
  logic [CNT_BITS-1:0]                flush_cnt;
  logic                               s1_makes_result;
  logic                               s1_advance;

  // Only the low len bits of the stored code enter the stream.
  assign code_masked = rd_entry.code & MAX_CODE_BITS'(low_mask({1'b0, rd_entry.len}));
  assign total       = {1'b0, fill_r} + {1'b0, rd_entry.len};
  // The low 64 bits join the accumulator; the bits above are the carry into the next word.
  assign shifted     = {{WORD_BITS{1'b0}}, code_masked} << fill_r;

  // Flush: ones pad the top of the partial byte unless the last code started with a one.
  // Accumulator bits at and above the fill count are always zero, so no mask is needed.
  assign flush_cnt  = CNT_BITS'(({1'b0, fill_r} + 7'd7) >> 3);
  assign pad_mask   = ({{(WORD_BITS-8){1'b0}}, BYTE_MASK} << {fill_r[FILL_BITS-1:3], 3'b000})
                      & ~low_mask({1'b0, fill_r});
  assign flush_word = ((fill_r[2:0] != 3'd0) && !low_bit_r) ? (acc_r | pad_mask) : acc_r;

  always_comb begin
    s1_makes_result = 1'b0;
    if (s1_valid_r) begin
      case (s1_op_r)
        OP_ENCODE: s1_makes_result = total[FILL_BITS];
        OP_FLUSH:  s1_makes_result = 1'b1;
        default:   s1_makes_result = 1'b0;
      endcase
    end
  end

  // The stage moves on unless its result would land on an output word still waiting.
  assign s1_advance = !s1_makes_result || !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_advance;

  always_comb begin
    acc_nxt       = acc_r;
    fill_nxt      = fill_r;
    low_bit_nxt   = low_bit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_word_nxt  = out_word_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    s1_valid_nxt  = s1_valid_r && !s1_advance;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
    if (s1_valid_r && s1_advance) begin
      case (s1_op_r)
        OP_ENCODE: begin
          low_bit_nxt = rd_entry.code[0];
          fill_nxt    = total[FILL_BITS-1:0];
          if (total[FILL_BITS]) begin
            // Word full: emit it and keep the overflow bits.
            acc_nxt       = {{(WORD_BITS-MAX_CODE_BITS){1'b0}},
                             shifted[WORD_BITS +: MAX_CODE_BITS]};
            out_valid_nxt = 1'b1;
            out_word_nxt  = acc_r | shifted[WORD_BITS-1:0];
            out_cnt_nxt   = FULL_WORD_BYTES;
            out_last_nxt  = 1'b0;
          end else begin
            acc_nxt = acc_r | shifted[WORD_BITS-1:0];
          end
        end
        OP_FLUSH: begin
          acc_nxt       = '0;
          fill_nxt      = '0;
          low_bit_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          out_word_nxt  = flush_word;
          out_cnt_nxt   = flush_cnt;
          out_last_nxt  = 1'b1;
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      fill_r      <= '0;
      low_bit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      acc_r       <= acc_nxt;
      fill_r      <= fill_nxt;
      low_bit_r   <= low_bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r <= in_tuser;
    end
    out_word_r <= out_word_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_cnt_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/hufp_checker.sv -----
// Port-level assertions for the Huffman table bit packer, bound to its top level.
// Depends only on the ports of huffman_table_bit_packer_core.
module hufp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  // A word that is not the end of the stream is always a full eight bytes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == 4'd8)
    else $error("full word without byte count eight");

  // An end-of-stream word never claims more than eight bytes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser <= 4'd8)
    else $error("flush byte count above eight");

  // An empty flush carries no bits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tuser == 4'd0 |-> out_tdata == 64'd0)
    else $error("empty flush with nonzero data");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

endmodule

bind huffman_table_bit_packer_core hufp_checker u_hufp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
